FILE: design/mef_pkg.sv
// Shared constants and types for the median-then-EMA sample filter.
package mef_pkg;

   localparam int WINDOW_SIZE = 5;
   localparam int MED_IDX     = WINDOW_SIZE / 2;
   localparam int IDX_W       = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
   localparam int RANK_W      = $clog2(WINDOW_SIZE + 1);

   localparam int SAMPLE_W = 16;
   localparam int SMOOTH_W = 32;
   localparam int WEIGHT_W = 16;
   localparam int FRAC_W   = 16;
   localparam int PROD_W   = SMOOTH_W + 1 + WEIGHT_W + 1;
   localparam int DELTA_W  = PROD_W - FRAC_W;

   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd6554;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [SMOOTH_W-1:0] smooth_type;
   typedef logic        [WEIGHT_W-1:0] weight_type;
   typedef logic        [IDX_W-1:0]    index_type;
   typedef logic        [RANK_W-1:0]   rank_type;

endpackage

FILE: design/mef_cell.sv
// One window cell: holds a sample, shifts it on, and ranks it against the window.
module mef_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift_en,
   input  mef_pkg::sample_type shift_data,
   input  mef_pkg::index_type  cell_index,
   input  mef_pkg::sample_type window [mef_pkg::WINDOW_SIZE],
   output mef_pkg::sample_type value,
   output logic                is_median
);

   mef_pkg::sample_type value_ff;
   mef_pkg::rank_type   rank;

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else if (shift_en) begin
         value_ff <= shift_data;
      end
   end

   // ties broken by position so every cell gets a distinct rank
   always_comb begin
      rank = '0;
      for (int j = 0; j < mef_pkg::WINDOW_SIZE; j++) begin
         if ((window[j] < value_ff) ||
             ((mef_pkg::IDX_W'(j) < cell_index) && (window[j] == value_ff))) begin
            rank = rank + mef_pkg::RANK_W'(1);
         end
      end
   end

   assign value     = value_ff;
   assign is_median = (rank == mef_pkg::RANK_W'(mef_pkg::MED_IDX));

endmodule

FILE: design/mef_blend.sv
// Smoothed value register and its EMA update from the median.
module mef_blend (
   input  logic                clock,
   input  logic                reset,
   input  logic                update,
   input  mef_pkg::sample_type median,
   input  mef_pkg::weight_type weight,
   output mef_pkg::smooth_type smoothed
);

   mef_pkg::smooth_type              smoothed_ff;
   mef_pkg::smooth_type              smoothed_in;
   mef_pkg::smooth_type              med_q;
   logic signed [mef_pkg::SMOOTH_W:0]   diff;
   logic signed [mef_pkg::WEIGHT_W:0]   weight_s;
   logic signed [mef_pkg::PROD_W-1:0]   prod;
   logic signed [mef_pkg::PROD_W-1:0]   rounded;
   logic signed [mef_pkg::DELTA_W-1:0]  delta;
   logic signed [mef_pkg::DELTA_W-1:0]  sum;

   assign med_q    = {median, {mef_pkg::FRAC_W{1'b0}}};
   assign diff     = {med_q[mef_pkg::SMOOTH_W-1], med_q}
                     - {smoothed_ff[mef_pkg::SMOOTH_W-1], smoothed_ff};
   assign weight_s = {1'b0, weight};
   assign prod     = diff * weight_s;
   assign rounded  = prod + mef_pkg::PROD_W'(32768);
   assign delta    = rounded[mef_pkg::PROD_W-1:mef_pkg::FRAC_W];
   assign sum      = mef_pkg::DELTA_W'(smoothed_ff) + delta;

   always_comb begin
      if (smoothed_ff <= 0) begin
         smoothed_in = med_q;
      end else begin
         smoothed_in = sum[mef_pkg::SMOOTH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smoothed_ff <= '0;
      end else if (update) begin
         smoothed_ff <= smoothed_in;
      end
   end

   assign smoothed = smoothed_ff;

endmodule

FILE: design/median_then_ema_sample_filter_top.sv
// Top level of the median-then-EMA sample filter.
// Usage:
//   Request channel (req_*): one measurement round per request, a thermistor
//   and a source reading, each with its own ok flag.
//   Response channel (rsp_*): exactly one response per request, in order:
//   smoothed source (Q16.16), held thermistor reading, healthy, calc_ready.
//   CSR channel (csr_*): writes blend_weight (Q0.16); always ready. Write it
//   only while no request is in flight.
// Stages: a response is valid once its request has passed three registered stages
//   (window cells, median register, smoothed/output register).
// Throughput: one request per cycle while no stage is stalled. The median
//   comes from a row of cells that each rank their own sample against the
//   window; a multiply-add loop updates the smoothed value per ok sample.
// Reset: window, smoothed value and held thermistor clear to zero,
//   blend_weight returns to 6554, all stages empty.
// Stall: each stage holds while the one after it is full and stalled; the
//   block keeps taking requests until all three stages are full, so a
//   waiting response does not stop intake right away.
module median_then_ema_sample_filter_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  mef_pkg::sample_type req_therm_sample,
   input  logic                req_therm_ok,
   input  mef_pkg::sample_type req_source_sample,
   input  logic                req_source_ok,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output mef_pkg::smooth_type rsp_source_smoothed,
   output mef_pkg::sample_type rsp_therm_latest,
   output logic                rsp_healthy,
   output logic                rsp_calc_ready,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  mef_pkg::weight_type csr_blend_weight
);

   mef_pkg::weight_type weight_ff;
   mef_pkg::sample_type held_ff;

   logic                s1_valid_ff;
   mef_pkg::sample_type s1_therm_ff;
   logic                s1_healthy_ff;
   logic                s1_source_ok_ff;

   logic                s2_valid_ff;
   mef_pkg::sample_type s2_therm_ff;
   logic                s2_healthy_ff;
   logic                s2_source_ok_ff;
   mef_pkg::sample_type median_ff;

   logic                s3_valid_ff;
   mef_pkg::sample_type s3_therm_ff;
   logic                s3_healthy_ff;

   logic s1_ready, s2_ready, s3_ready;
   logic mv1, mv2, mv3;
   logic shift_en;

   mef_pkg::sample_type cell_value [mef_pkg::WINDOW_SIZE];
   logic [mef_pkg::WINDOW_SIZE-1:0] cell_is_median;
   mef_pkg::sample_type median_in;
   mef_pkg::smooth_type smoothed;

   assign s3_ready  = !s3_valid_ff || rsp_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;
   assign mv1       = req_valid && s1_ready;
   assign mv2       = s1_valid_ff && s2_ready;
   assign mv3       = s2_valid_ff && s3_ready;
   assign shift_en  = mv1 && req_source_ok;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= mef_pkg::WEIGHT_RESET;
      end else if (csr_valid) begin
         weight_ff <= csr_blend_weight;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else if (mv1 && req_therm_ok) begin
         held_ff <= req_therm_sample;
      end
   end

   // window: a new source sample enters cell 0, the oldest drops off the end
   for (genvar i = 0; i < mef_pkg::WINDOW_SIZE; i++) begin : g_cell
      mef_pkg::sample_type shift_data;
      if (i == 0) begin : g_head
         assign shift_data = req_source_sample;
      end else begin : g_link
         assign shift_data = cell_value[i-1];
      end
      mef_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (shift_en),
         .shift_data (shift_data),
         .cell_index (mef_pkg::IDX_W'(i)),
         .window     (cell_value),
         .value      (cell_value[i]),
         .is_median  (cell_is_median[i])
      );
   end

   always_comb begin
      median_in = '0;
      for (int i = 0; i < mef_pkg::WINDOW_SIZE; i++) begin
         median_in = median_in | (cell_value[i] & {mef_pkg::SAMPLE_W{cell_is_median[i]}});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mv1) begin
         s1_therm_ff     <= req_therm_ok ? req_therm_sample : held_ff;
         s1_healthy_ff   <= req_therm_ok && req_source_ok;
         s1_source_ok_ff <= req_source_ok;
      end
      if (mv2) begin
         s2_therm_ff     <= s1_therm_ff;
         s2_healthy_ff   <= s1_healthy_ff;
         s2_source_ok_ff <= s1_source_ok_ff;
         median_ff       <= median_in;
      end
      if (mv3) begin
         s3_therm_ff   <= s2_therm_ff;
         s3_healthy_ff <= s2_healthy_ff;
      end
   end

   mef_blend u_blend (
      .clock    (clock),
      .reset    (reset),
      .update   (mv3 && s2_source_ok_ff),
      .median   (median_ff),
      .weight   (weight_ff),
      .smoothed (smoothed)
   );

   assign rsp_valid           = s3_valid_ff;
   assign rsp_source_smoothed = smoothed;
   assign rsp_therm_latest    = s3_therm_ff;
   assign rsp_healthy         = s3_healthy_ff;
   assign rsp_calc_ready      = s3_healthy_ff && (s3_therm_ff < 0) && (smoothed > 0);

endmodule

FILE: design/mef_checker.sv
// Port-level checker for the median-then-EMA sample filter, bound to the top level.
module mef_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input mef_pkg::smooth_type rsp_source_smoothed,
   input mef_pkg::sample_type rsp_therm_latest,
   input logic                rsp_healthy,
   input logic                rsp_calc_ready,
   input logic                csr_ready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_source_smoothed))
      else $error("stalled response changed");

   a_calc_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_calc_ready |->
         rsp_healthy && rsp_therm_latest[15] && !rsp_source_smoothed[31])
      else $error("calc_ready without its conditions");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled with output free");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && csr_ready)
      else $error("response valid after reset");

endmodule

bind median_then_ema_sample_filter_top mef_checker u_mef_checker (
   .clock               (clock),
   .reset               (reset),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_source_smoothed (rsp_source_smoothed),
   .rsp_therm_latest    (rsp_therm_latest),
   .rsp_healthy         (rsp_healthy),
   .rsp_calc_ready      (rsp_calc_ready),
   .csr_ready           (csr_ready)
);
